@@ sv/faie_pkg.sv @@
// Package for the faulting access instruction executor.
// Holds the opcodes, ModR/M bytes, status and region codes, region boundaries, flag masks and the result struct.
// No dependencies.
package faie_pkg;

    // Status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_NOFAULT = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    // Region codes
    localparam logic [1:0] RGN_NONE = 2'd0;
    localparam logic [1:0] RGN_HMEM = 2'd1;
    localparam logic [1:0] RGN_ROM  = 2'd2;
    localparam logic [1:0] RGN_ERAM = 2'd3;

    // Region boundaries
    localparam logic [15:0] HMEM_START   = 16'hF000;
    localparam logic [15:0] ERAM_START   = 16'hA000;
    localparam logic [15:0] NOFAULT_A_LO = 16'h8000;
    localparam logic [15:0] NOFAULT_B_LO = 16'hC000;

    // Flag masks and single flags
    localparam logic [11:0] MASK_OF_ZF_CF = 12'h841;
    localparam logic [11:0] MASK_ARITH    = 12'h8D5;
    localparam logic [11:0] MASK_LOGIC    = 12'h8C5;
    localparam logic [11:0] MASK_INCDEC   = 12'h8D4;
    localparam logic [11:0] MASK_SHIFT    = 12'h0C5;
    localparam logic [11:0] FLAG_CF       = 12'h001;
    localparam logic [11:0] FLAG_AF       = 12'h010;
    localparam logic [11:0] FLAG_ZF       = 12'h040;

    // First opcode bytes
    localparam logic [7:0] OP_OR_R8    = 8'h0A;
    localparam logic [7:0] OP_SUB_R8   = 8'h2A;
    localparam logic [7:0] OP_CMP_R8   = 8'h3A;
    localparam logic [7:0] OP_OPSIZE   = 8'h66;
    localparam logic [7:0] OP_GRP1_IMM = 8'h80;
    localparam logic [7:0] OP_MOV_ST8  = 8'h88;
    localparam logic [7:0] OP_MOV_ST16 = 8'h89;
    localparam logic [7:0] OP_MOV_LD8  = 8'h8A;
    localparam logic [7:0] OP_MOV_LDAL = 8'hA0;
    localparam logic [7:0] OP_MOV_STAL = 8'hA2;
    localparam logic [7:0] OP_MOV_IMM  = 8'hC6;
    localparam logic [7:0] OP_SHIFT1   = 8'hD0;
    localparam logic [7:0] OP_TEST_IMM = 8'hF6;
    localparam logic [7:0] OP_INCDEC   = 8'hFE;

    // ModR/M bytes
    localparam logic [7:0] MRM_AL_CX  = 8'h01;
    localparam logic [7:0] MRM_AL_DX  = 8'h02;
    localparam logic [7:0] MRM_CL_DX  = 8'h0A;
    localparam logic [7:0] MRM_BL_DX  = 8'h1A;
    localparam logic [7:0] MRM_AND_DX = 8'h22;
    localparam logic [7:0] MRM_CH_DX  = 8'h2A;
    localparam logic [7:0] MRM_BH_DX  = 8'h3A;
    localparam logic [7:0] MRM_BP_ABS = 8'h2D;
    localparam logic [7:0] MRM_OR_DX  = 8'h0A;
    localparam logic [7:0] MRM_RCR_DX = 8'h1A;
    localparam logic [7:0] MRM_SHR_DX = 8'h2A;
    localparam logic [7:0] MRM_INC_DX = 8'h02;
    localparam logic [7:0] MRM_DEC_DX = 8'h0A;

    // One result transaction
    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  instr_length;
        logic [7:0]  al_out;
        logic        al_written;
        logic [11:0] flags_out;
        logic [1:0]  read_region;
        logic [15:0] read_offset;
        logic [1:0]  write_count;
        logic [1:0]  write_region;
        logic [15:0] write_offset;
        logic [15:0] write_data;
    } t_result;

endpackage

@@ sv/faie_region.sv @@
// Address to region and offset mapping for the executor.
// Depends on faie_pkg.
module faie_region (
    input  logic [15:0] i_addr,
    output logic [1:0]  o_region,
    output logic [15:0] o_offset
);

    // Split the 64 KiB space into high memory, ROM and external RAM
    always_comb begin
        if (i_addr >= faie_pkg::HMEM_START) begin
            o_region = faie_pkg::RGN_HMEM;
            o_offset = i_addr - faie_pkg::HMEM_START;
        end else if (i_addr < faie_pkg::NOFAULT_A_LO) begin
            o_region = faie_pkg::RGN_ROM;
            o_offset = i_addr;
        end else begin
            o_region = faie_pkg::RGN_ERAM;
            o_offset = i_addr - faie_pkg::ERAM_START;
        end
    end

endmodule

@@ sv/faie_exec.sv @@
// Decode and execute logic for one faulting instruction.
// Depends on faie_pkg and faie_region.
module faie_exec (
    input  logic [39:0]        i_instr_bytes,
    input  logic [7:0]         i_al_value,
    input  logic [15:0]        i_bx_value,
    input  logic [15:0]        i_cx_value,
    input  logic [15:0]        i_dx_value,
    input  logic [15:0]        i_bp_value,
    input  logic [11:0]        i_flags_in,
    input  logic [7:0]         i_mem_byte,
    input  logic [16:0]        i_fault_offset,
    output faie_pkg::t_result  o_result
);

    logic [7:0]  b0, b1, b2, b3, b4;
    logic [15:0] fo;
    logic [1:0]  st;
    logic [2:0]  len;
    logic [7:0]  al_n;
    logic        al_w;
    logic [11:0] fl_n;
    logic        rd, wr;
    logic [15:0] raddr, waddr, wdata;
    logic [1:0]  wcnt;
    logic [7:0]  r;
    logic [1:0]  rd_rgn, wr_rgn;
    logic [15:0] rd_off, wr_off;

    assign b0 = i_instr_bytes[7:0];
    assign b1 = i_instr_bytes[15:8];
    assign b2 = i_instr_bytes[23:16];
    assign b3 = i_instr_bytes[31:24];
    assign b4 = i_instr_bytes[39:32];
    assign fo = i_fault_offset[15:0];

    // Check the fault offset, then decode and execute
    always_comb begin
        st    = faie_pkg::ST_DONE;
        len   = 3'd0;
        al_n  = i_al_value;
        al_w  = 1'b0;
        fl_n  = i_flags_in;
        rd    = 1'b0;
        wr    = 1'b0;
        raddr = i_dx_value;
        waddr = i_dx_value;
        wdata = 16'd0;
        wcnt  = 2'd0;
        r     = 8'd0;
        if (i_fault_offset[16]) begin
            st = faie_pkg::ST_OUTSIDE;
        end else if ((fo >= faie_pkg::NOFAULT_A_LO && fo < faie_pkg::ERAM_START) ||
                     (fo >= faie_pkg::NOFAULT_B_LO && fo < faie_pkg::HMEM_START)) begin
            st = faie_pkg::ST_NOFAULT;
        end else begin
            case (b0)
                faie_pkg::OP_OR_R8: begin
                    if (b1 == faie_pkg::MRM_AL_DX) begin
                        rd   = 1'b1;
                        r    = i_al_value | i_mem_byte;
                        al_n = r;
                        al_w = 1'b1;
                        fl_n = (i_flags_in & ~faie_pkg::MASK_OF_ZF_CF) |
                               ((r == 8'd0) ? faie_pkg::FLAG_ZF : 12'd0);
                        len  = 3'd2;
                    end else begin
                        st = faie_pkg::ST_UNKNOWN;
                    end
                end
                faie_pkg::OP_SUB_R8, faie_pkg::OP_CMP_R8: begin
                    if (b1 == faie_pkg::MRM_AL_DX) begin
                        rd   = 1'b1;
                        fl_n = (i_flags_in & ~faie_pkg::MASK_ARITH) |
                               ((i_al_value == i_mem_byte) ? faie_pkg::FLAG_ZF : 12'd0) |
                               ((i_mem_byte > i_al_value) ? faie_pkg::FLAG_CF : 12'd0) |
                               ((i_al_value[3:0] < i_mem_byte[3:0]) ?
                                    faie_pkg::FLAG_AF : 12'd0);
                        if (b0 == faie_pkg::OP_SUB_R8) begin
                            al_n = i_al_value - i_mem_byte;
                            al_w = 1'b1;
                        end
                        len  = 3'd2;
                    end else begin
                        st = faie_pkg::ST_UNKNOWN;
                    end
                end
                faie_pkg::OP_OPSIZE: begin
                    if (b1 == faie_pkg::OP_MOV_ST16 && b2 == faie_pkg::MRM_BP_ABS) begin
                        wr    = 1'b1;
                        waddr = {b4, b3};
                        wdata = i_bp_value;
                        wcnt  = 2'd2;
                        len   = 3'd7;
                    end else begin
                        st = faie_pkg::ST_UNKNOWN;
                    end
                end
                faie_pkg::OP_GRP1_IMM: begin
                    if (b1 == faie_pkg::MRM_AND_DX || b1 == faie_pkg::MRM_OR_DX) begin
                        rd    = 1'b1;
                        r     = (b1 == faie_pkg::MRM_AND_DX) ? (i_mem_byte & b2) :
                                                               (i_mem_byte | b2);
                        wr    = 1'b1;
                        wdata = {8'd0, r};
                        wcnt  = 2'd1;
                        fl_n  = (i_flags_in & ~faie_pkg::MASK_LOGIC) |
                                ((r == 8'd0) ? faie_pkg::FLAG_ZF : 12'd0);
                        len   = 3'd3;
                    end else begin
                        st = faie_pkg::ST_UNKNOWN;
                    end
                end
                faie_pkg::OP_MOV_ST8: begin
                    wr   = 1'b1;
                    wcnt = 2'd1;
                    len  = 3'd2;
                    case (b1)
                        faie_pkg::MRM_AL_CX: begin
                            waddr = i_cx_value;
                            wdata = {8'd0, i_al_value};
                        end
                        faie_pkg::MRM_AL_DX: wdata = {8'd0, i_al_value};
                        faie_pkg::MRM_CL_DX: wdata = {8'd0, i_cx_value[7:0]};
                        faie_pkg::MRM_BL_DX: wdata = {8'd0, i_bx_value[7:0]};
                        faie_pkg::MRM_CH_DX: wdata = {8'd0, i_cx_value[15:8]};
                        faie_pkg::MRM_BH_DX: wdata = {8'd0, i_bx_value[15:8]};
                        default: begin
                            wr   = 1'b0;
                            wcnt = 2'd0;
                            len  = 3'd0;
                            st   = faie_pkg::ST_UNKNOWN;
                        end
                    endcase
                end
                faie_pkg::OP_MOV_LD8: begin
                    if (b1 == faie_pkg::MRM_AL_CX || b1 == faie_pkg::MRM_AL_DX) begin
                        rd    = 1'b1;
                        raddr = (b1 == faie_pkg::MRM_AL_CX) ? i_cx_value : i_dx_value;
                        al_n  = i_mem_byte;
                        al_w  = 1'b1;
                        len   = 3'd2;
                    end else begin
                        st = faie_pkg::ST_UNKNOWN;
                    end
                end
                faie_pkg::OP_MOV_LDAL: begin
                    rd    = 1'b1;
                    raddr = {b2, b1};
                    al_n  = i_mem_byte;
                    al_w  = 1'b1;
                    len   = 3'd5;
                end
                faie_pkg::OP_MOV_STAL: begin
                    wr    = 1'b1;
                    waddr = {b2, b1};
                    wdata = {8'd0, i_al_value};
                    wcnt  = 2'd1;
                    len   = 3'd5;
                end
                faie_pkg::OP_MOV_IMM: begin
                    if (b1 == faie_pkg::MRM_AL_DX) begin
                        wr    = 1'b1;
                        wdata = {8'd0, b2};
                        wcnt  = 2'd1;
                        len   = 3'd3;
                    end else begin
                        st = faie_pkg::ST_UNKNOWN;
                    end
                end
                faie_pkg::OP_SHIFT1: begin
                    if (b1 == faie_pkg::MRM_RCR_DX || b1 == faie_pkg::MRM_SHR_DX) begin
                        // Rotate drops the carry-in: plain rotate right by one
                        rd    = 1'b1;
                        r     = {(b1 == faie_pkg::MRM_RCR_DX) & i_mem_byte[0],
                                 i_mem_byte[7:1]};
                        wr    = 1'b1;
                        wdata = {8'd0, r};
                        wcnt  = 2'd1;
                        fl_n  = (i_flags_in & ~faie_pkg::MASK_SHIFT) |
                                ((r == 8'd0) ? faie_pkg::FLAG_ZF : 12'd0) |
                                {11'd0, i_mem_byte[0]};
                        len   = 3'd2;
                    end else begin
                        st = faie_pkg::ST_UNKNOWN;
                    end
                end
                faie_pkg::OP_TEST_IMM: begin
                    if (b1 == faie_pkg::MRM_AL_DX) begin
                        rd   = 1'b1;
                        r    = i_mem_byte & b2;
                        fl_n = (i_flags_in & ~faie_pkg::MASK_LOGIC) |
                               ((r == 8'd0) ? faie_pkg::FLAG_ZF : 12'd0);
                        len  = 3'd3;
                    end else begin
                        st = faie_pkg::ST_UNKNOWN;
                    end
                end
                faie_pkg::OP_INCDEC: begin
                    if (b1 == faie_pkg::MRM_INC_DX || b1 == faie_pkg::MRM_DEC_DX) begin
                        rd = 1'b1;
                        if (b1 == faie_pkg::MRM_INC_DX) begin
                            r    = i_mem_byte + 8'd1;
                            fl_n = (i_flags_in & ~faie_pkg::MASK_INCDEC) |
                                   ((r[3:0] == 4'd0) ? faie_pkg::FLAG_AF : 12'd0);
                        end else begin
                            r    = i_mem_byte - 8'd1;
                            fl_n = (i_flags_in & ~faie_pkg::MASK_INCDEC) |
                                   ((i_mem_byte[3:0] == 4'd0) ? faie_pkg::FLAG_AF : 12'd0);
                        end
                        fl_n  = fl_n | ((r == 8'd0) ? faie_pkg::FLAG_ZF : 12'd0);
                        wr    = 1'b1;
                        wdata = {8'd0, r};
                        wcnt  = 2'd1;
                        len   = 3'd2;
                    end else begin
                        st = faie_pkg::ST_UNKNOWN;
                    end
                end
                default: st = faie_pkg::ST_UNKNOWN;
            endcase
        end
    end

    // Map read and write addresses to regions
    faie_region u_rd_rgn (
        .i_addr   (raddr),
        .o_region (rd_rgn),
        .o_offset (rd_off)
    );

    faie_region u_wr_rgn (
        .i_addr   (waddr),
        .o_region (wr_rgn),
        .o_offset (wr_off)
    );

    // Pack the result, zeroing unused request fields
    always_comb begin
        o_result.status       = st;
        o_result.instr_length = len;
        o_result.al_out       = al_n;
        o_result.al_written   = al_w;
        o_result.flags_out    = fl_n;
        o_result.read_region  = rd ? rd_rgn : faie_pkg::RGN_NONE;
        o_result.read_offset  = rd ? rd_off : 16'd0;
        o_result.write_count  = wcnt;
        o_result.write_region = wr ? wr_rgn : faie_pkg::RGN_NONE;
        o_result.write_offset = wr ? wr_off : 16'd0;
        o_result.write_data   = wr ? wdata : 16'd0;
    end

endmodule

@@ sv/faulting_access_instruction_executor.sv @@
// Top level of the faulting access instruction executor.
// Input register, faie_exec decode/execute logic, result register.
// Depends on faie_pkg and faie_exec.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_stall   | instruction bytes, registers, flags
//  out     | output    | o_out_valid / i_out_stall | status, length, AL, flags, requests
//
// One transaction per cycle sustained while the output is not stalled; a result
// becomes valid once it has passed the input register and then the result register.
// Reset is synchronous and active low; it empties both register stages.
// A stall on the output holds the result register; the input register still
// takes a new transaction while empty, and o_in_stall rises only when both are full
// and the output is stalled.
module faulting_access_instruction_executor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [39:0] i_instr_bytes,
    input  logic [7:0]  i_al_value,
    input  logic [15:0] i_bx_value,
    input  logic [15:0] i_cx_value,
    input  logic [15:0] i_dx_value,
    input  logic [15:0] i_bp_value,
    input  logic [11:0] i_flags_in,
    input  logic [7:0]  i_mem_byte,
    input  logic [16:0] i_fault_offset,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [2:0]  o_instr_length,
    output logic [7:0]  o_al_out,
    output logic        o_al_written,
    output logic [11:0] o_flags_out,
    output logic [1:0]  o_read_region,
    output logic [15:0] o_read_offset,
    output logic [1:0]  o_write_count,
    output logic [1:0]  o_write_region,
    output logic [15:0] o_write_offset,
    output logic [15:0] o_write_data
);

    logic              r_s1_vld;
    logic [39:0]       r_instr_bytes;
    logic [7:0]        r_al_value;
    logic [15:0]       r_bx_value;
    logic [15:0]       r_cx_value;
    logic [15:0]       r_dx_value;
    logic [15:0]       r_bp_value;
    logic [11:0]       r_flags_in;
    logic [7:0]        r_mem_byte;
    logic [16:0]       r_fault_offset;
    logic              r_s2_vld;
    faie_pkg::t_result r_result;
    faie_pkg::t_result n_result;
    logic              s2_adv;
    logic              s1_adv;

    // Advance the result stage when it is empty or being taken
    assign s2_adv     = !r_s2_vld || !i_out_stall;
    assign s1_adv     = !r_s1_vld || s2_adv;
    assign o_in_stall = !s1_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_adv) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && i_in_valid) begin
            r_instr_bytes  <= i_instr_bytes;
            r_al_value     <= i_al_value;
            r_bx_value     <= i_bx_value;
            r_cx_value     <= i_cx_value;
            r_dx_value     <= i_dx_value;
            r_bp_value     <= i_bp_value;
            r_flags_in     <= i_flags_in;
            r_mem_byte     <= i_mem_byte;
            r_fault_offset <= i_fault_offset;
        end
    end

    faie_exec u_exec (
        .i_instr_bytes  (r_instr_bytes),
        .i_al_value     (r_al_value),
        .i_bx_value     (r_bx_value),
        .i_cx_value     (r_cx_value),
        .i_dx_value     (r_dx_value),
        .i_bp_value     (r_bp_value),
        .i_flags_in     (r_flags_in),
        .i_mem_byte     (r_mem_byte),
        .i_fault_offset (r_fault_offset),
        .o_result       (n_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (s2_adv) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv && r_s1_vld) begin
            r_result <= n_result;
        end
    end

    // Drive the output ports
    assign o_out_valid    = r_s2_vld;
    assign o_status       = r_result.status;
    assign o_instr_length = r_result.instr_length;
    assign o_al_out       = r_result.al_out;
    assign o_al_written   = r_result.al_written;
    assign o_flags_out    = r_result.flags_out;
    assign o_read_region  = r_result.read_region;
    assign o_read_offset  = r_result.read_offset;
    assign o_write_count  = r_result.write_count;
    assign o_write_region = r_result.write_region;
    assign o_write_offset = r_result.write_offset;
    assign o_write_data   = r_result.write_data;

endmodule

@@ sv/faie_chk.sv @@
// Port-level checker for the faulting access instruction executor.
// Depends on faie_pkg; bound to the top level at the end of this file.
module faie_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [2:0]  o_instr_length,
    input logic [1:0]  o_read_region,
    input logic [1:0]  o_write_count,
    input logic [1:0]  o_write_region,
    input logic [15:0] o_write_data
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) &&
                                       $stable(o_write_data))
        else $error("stalled result changed");

    // Drop all requests on an error
    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != faie_pkg::ST_DONE |->
            o_instr_length == 3'd0 && o_write_count == 2'd0 &&
            o_read_region == faie_pkg::RGN_NONE)
        else $error("error result carries a request");

    // A completed instruction always has a length
    a_done_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == faie_pkg::ST_DONE |-> o_instr_length != 3'd0)
        else $error("completed instruction with zero length");

    // No write means no write region and no data
    a_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_write_count == 2'd0 |->
            o_write_region == faie_pkg::RGN_NONE && o_write_data == 16'd0)
        else $error("write fields set without a write");

    // Empty the output after reset
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind faulting_access_instruction_executor faie_chk u_faie_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_instr_length (o_instr_length),
    .o_read_region  (o_read_region),
    .o_write_count  (o_write_count),
    .o_write_region (o_write_region),
    .o_write_data   (o_write_data)
);
